>>> rtl/core/sts_pkg.sv
// ----------------------------------------------------------------------------
// sts_pkg
// Shared types, token kinds, character codes and keyword table for the
// streaming sql token scanner.
// ----------------------------------------------------------------------------
package sts_pkg;

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_text;
    } sts_in_t;

    typedef struct packed {
        logic [5:0]  token_kind;
        logic [15:0] token_start;
        logic [15:0] token_length;
        logic        last_of_run;
        logic        offset_overflow;
    } sts_out_t;

    // up to two result items pushed per accepted input item
    typedef struct packed {
        logic [1:0] count;
        sts_out_t   e0;
        sts_out_t   e1;
    } sts_push_t;

    typedef enum logic [10:0] {
        MODE_IDLE    = 11'b000_0000_0001,
        MODE_WORD    = 11'b000_0000_0010,
        MODE_INT     = 11'b000_0000_0100,
        MODE_FRAC    = 11'b000_0000_1000,
        MODE_STR     = 11'b000_0001_0000,
        MODE_STRQ    = 11'b000_0010_0000,
        MODE_DASH    = 11'b000_0100_0000,
        MODE_COMMENT = 11'b000_1000_0000,
        MODE_LT      = 11'b001_0000_0000,
        MODE_GT      = 11'b010_0000_0000,
        MODE_BANG    = 11'b100_0000_0000
    } scan_mode_t;

    // token kinds
    localparam logic [5:0] K_END   = 6'd0;
    localparam logic [5:0] K_IDENT = 6'd1;
    localparam logic [5:0] K_NUM   = 6'd2;
    localparam logic [5:0] K_STR   = 6'd3;
    localparam logic [5:0] K_EQ    = 6'd4;
    localparam logic [5:0] K_NE    = 6'd5;
    localparam logic [5:0] K_LT    = 6'd6;
    localparam logic [5:0] K_LE    = 6'd7;
    localparam logic [5:0] K_GT    = 6'd8;
    localparam logic [5:0] K_GE    = 6'd9;
    localparam logic [5:0] K_COMMA = 6'd10;
    localparam logic [5:0] K_SEMI  = 6'd11;
    localparam logic [5:0] K_LPAR  = 6'd12;
    localparam logic [5:0] K_RPAR  = 6'd13;
    localparam logic [5:0] K_STAR  = 6'd14;
    localparam logic [5:0] K_BAD   = 6'd15;
    localparam logic [5:0] K_KW0   = 6'd16;

    // character codes
    localparam logic [7:0] CH_TAB        = 8'h09;
    localparam logic [7:0] CH_LF         = 8'h0A;
    localparam logic [7:0] CH_CR         = 8'h0D;
    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_BANG       = 8'h21;
    localparam logic [7:0] CH_QUOTE      = 8'h27;
    localparam logic [7:0] CH_LPAREN     = 8'h28;
    localparam logic [7:0] CH_RPAREN     = 8'h29;
    localparam logic [7:0] CH_STAR       = 8'h2A;
    localparam logic [7:0] CH_COMMA      = 8'h2C;
    localparam logic [7:0] CH_DASH       = 8'h2D;
    localparam logic [7:0] CH_DOT        = 8'h2E;
    localparam logic [7:0] CH_DIGIT_0    = 8'h30;
    localparam logic [7:0] CH_DIGIT_9    = 8'h39;
    localparam logic [7:0] CH_SEMI       = 8'h3B;
    localparam logic [7:0] CH_LT         = 8'h3C;
    localparam logic [7:0] CH_EQ         = 8'h3D;
    localparam logic [7:0] CH_GT         = 8'h3E;
    localparam logic [7:0] CH_UPPER_A    = 8'h41;
    localparam logic [7:0] CH_UPPER_Z    = 8'h5A;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_LOWER_A    = 8'h61;
    localparam logic [7:0] CH_LOWER_Z    = 8'h7A;
    localparam logic [7:0] CASE_OFFSET   = 8'h20;

    // keyword table
    localparam int KW_DEPTH = 9;
    localparam int KW_COUNT = 21;
    localparam int KW_BITS  = 8 * KW_DEPTH;

    typedef logic [7:0] kw_chars_t [KW_DEPTH];

    localparam logic [KW_BITS-1:0] KW_TEXT [KW_COUNT] = '{
        "SELECT", "INSERT", "UPDATE", "DELETE", "FROM", "WHERE", "ORDER", "BY",
        "INTO", "VALUES", "SET", "BEGIN", "COMMIT", "ROLLBACK", "JOIN",
        "INNERJOIN", "LEFTJOIN", "RIGHTJOIN", "FULLJOIN", "OUTERJOIN", "ON"
    };
    localparam logic [3:0] KW_LEN [KW_COUNT] = '{
        4'd6, 4'd6, 4'd6, 4'd6, 4'd4, 4'd5, 4'd5, 4'd2, 4'd4, 4'd6, 4'd3,
        4'd5, 4'd6, 4'd8, 4'd4, 4'd9, 4'd8, 4'd9, 4'd8, 4'd9, 4'd2
    };
    localparam logic [3:0] KW_DEPTH_C = 4'd9;

    // result queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;

endpackage

>>> rtl/core/sql_token_scanner_top.sv
// ----------------------------------------------------------------------------
// sql_token_scanner_top
// Streaming sql lexer: one text byte per item, tokens out with kind,
// start offset and length.
// ----------------------------------------------------------------------------
// tokens enter the result queue on the clock edge that accepts the item that completes them
// throughput: one item per cycle while results drain; an item that yields
//   two tokens hands them out one after the other through the single output port
// ready holds while the four-entry result queue has room for two tokens
// reset: asynchronous, scanner idle at offset zero and result queue empty
module sql_token_scanner_top
    import sts_pkg::*;
#(
    parameter int OFFSET_BITS = 16
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     text_valid,
    output logic     text_ready,
    input  sts_in_t  text_item,
    output logic     tok_valid,
    input  logic     tok_ready,
    output sts_out_t tok_item
);

    logic      accept;
    sts_push_t push;

    assign accept = text_valid && text_ready;

    sts_scan #(.OFFSET_BITS(OFFSET_BITS)) u_scan (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (text_item),
        .push   (push)
    );

    sts_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (text_ready),
        .tok_valid (tok_valid),
        .tok_ready (tok_ready),
        .tok_item  (tok_item)
    );

`ifndef NO_ASSERTIONS
    // an end marker always yields at least the end token
    a_end_pushes: assert property (@(posedge clk) disable iff (!rst_n)
        accept && text_item.end_of_text |-> push.count != 2'd0)
        else $error("end marker produced no token");

    // with two tokens from one item only the second closes the run
    a_pair_last: assert property (@(posedge clk) disable iff (!rst_n)
        push.count == 2'd2 |-> !push.e0.last_of_run && push.e1.last_of_run)
        else $error("last_of_run misplaced in token pair");

    // the end token closes its run and has no length
    a_end_token: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && tok_item.token_kind == K_END |->
            tok_item.last_of_run && tok_item.token_length == 16'd0)
        else $error("malformed end token");
`endif

endmodule

>>> rtl/core/sts_kw_match.sv
// ----------------------------------------------------------------------------
// sts_kw_match
// Compares the buffered upper-case word against all keywords in parallel
// and returns the keyword kind, or identifier when nothing matches or the word is too long.
// ----------------------------------------------------------------------------
module sts_kw_match
    import sts_pkg::*;
(
    input  kw_chars_t  chars,
    input  logic [3:0] word_count,
    input  logic       word_too_long,
    output logic [5:0] kind
);

    always_comb
    begin
        logic [KW_BITS-1:0] kw_word;
        logic               match;
        kind = K_IDENT;
        // descending so the lowest matching index wins
        for (int i = KW_COUNT - 1; i >= 0; i--)
        begin
            kw_word = KW_TEXT[i] << (8 * (KW_DEPTH - int'(KW_LEN[i])));
            match = (KW_LEN[i] == word_count);
            for (int j = 0; j < KW_DEPTH; j++)
            begin
                if ((4'(j) < KW_LEN[i]) && (chars[j] != kw_word[KW_BITS-1-8*j -: 8]))
                begin
                    match = 1'b0;
                end
            end
            if (match && !word_too_long)
            begin
                kind = K_KW0 + 6'(i);
            end
        end
    end

endmodule

>>> rtl/core/sts_tok_fmt.sv
// ----------------------------------------------------------------------------
// sts_tok_fmt
// Turns a token kind and its begin/end offsets into a result item,
// saturating start and length to 16 bits and flagging overflow.
// ----------------------------------------------------------------------------
module sts_tok_fmt
    import sts_pkg::*;
#(
    parameter int OFFSET_BITS = 16
)
(
    input  logic [5:0]           kind,
    input  logic [OFFSET_BITS-1:0] tok_begin,
    input  logic [OFFSET_BITS:0]   tok_end,
    input  logic                 sat,
    output sts_out_t             item
);

    localparam int CW = (OFFSET_BITS + 1 > 16) ? OFFSET_BITS + 1 : 17;
    localparam logic [CW-1:0] FIELD_MAX = CW'(16'hFFFF);

    logic [OFFSET_BITS:0] len;
    logic [CW-1:0]        begin_ext;
    logic [CW-1:0]        len_ext;
    logic                 begin_ovf;
    logic                 len_ovf;

    assign len       = tok_end - {1'b0, tok_begin};
    assign begin_ext = CW'(tok_begin);
    assign len_ext   = CW'(len);
    assign begin_ovf = begin_ext > FIELD_MAX;
    assign len_ovf   = len_ext > FIELD_MAX;

    always_comb
    begin
        item.token_kind      = kind;
        item.token_start     = begin_ovf ? 16'hFFFF : begin_ext[15:0];
        item.token_length    = len_ovf ? 16'hFFFF : len_ext[15:0];
        item.last_of_run     = 1'b0;
        item.offset_overflow = sat | begin_ovf | len_ovf;
    end

endmodule

>>> rtl/core/sts_scan.sv
// ----------------------------------------------------------------------------
// sts_scan
// Scanner state and per-byte step: mode update, flush of the pending token,
// dispatch of the new byte, and up to two result items per item.
// ----------------------------------------------------------------------------
module sts_scan
    import sts_pkg::*;
#(
    parameter int OFFSET_BITS = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      accept,
    input  sts_in_t   item,
    output sts_push_t push
);

    localparam logic [OFFSET_BITS-1:0] OFF_MAX = '1;

    scan_mode_t             mode_reg, mode_next;
    logic [OFFSET_BITS-1:0] begin_reg, begin_next;
    logic [OFFSET_BITS-1:0] offset_reg, offset_next;
    logic                   sat_reg, sat_next;
    logic [3:0]             cnt_reg, cnt_next;
    logic                   long_reg, long_next;
    kw_chars_t              kw_chars_reg;

    logic [7:0]           c;
    logic [7:0]           c_upper;
    logic                 is_alpha, is_digit, is_word;
    logic [OFFSET_BITS:0] p_ext, p1, b1;

    scan_mode_t ds_mode;
    logic       ds_tok;
    logic [5:0] ds_kind;
    logic       ds_word;

    logic                 fl_valid;
    logic [5:0]           fl_kind;
    logic [OFFSET_BITS:0] fl_end;
    logic [5:0]           word_kind;

    logic                 a_valid, b_valid;
    logic [5:0]           a_kind, b_kind;
    logic [OFFSET_BITS:0] a_end, b_end;
    logic                 kw_we;
    logic [3:0]           kw_idx;

    logic [5:0]             s0_kind;
    logic [OFFSET_BITS-1:0] s0_begin;
    logic [OFFSET_BITS:0]   s0_end;
    sts_out_t               e0_raw, e1_raw;

    assign c        = item.char_code;
    assign is_alpha = ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z)) ||
                      ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z));
    assign is_digit = (c >= CH_DIGIT_0) && (c <= CH_DIGIT_9);
    assign is_word  = is_alpha || is_digit || (c == CH_UNDERSCORE);
    assign c_upper  = ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z)) ? c - CASE_OFFSET : c;
    assign p_ext    = {1'b0, offset_reg};
    assign p1       = p_ext + 1'b1;
    assign b1       = {1'b0, begin_reg} + 1'b1;

    sts_kw_match u_kw_match (
        .chars         (kw_chars_reg),
        .word_count    (cnt_reg),
        .word_too_long (long_reg),
        .kind          (word_kind)
    );

    // what a byte does when seen from the idle mode
    always_comb
    begin
        ds_mode = MODE_IDLE;
        ds_tok  = 1'b0;
        ds_kind = K_BAD;
        ds_word = 1'b0;
        if ((c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF))
        begin
            ds_mode = MODE_IDLE;
        end
        else if (is_alpha || (c == CH_UNDERSCORE))
        begin
            ds_mode = MODE_WORD;
            ds_word = 1'b1;
        end
        else if (is_digit)
        begin
            ds_mode = MODE_INT;
        end
        else
        begin
            case (c)
                CH_QUOTE:  ds_mode = MODE_STR;
                CH_DASH:   ds_mode = MODE_DASH;
                CH_LT:     ds_mode = MODE_LT;
                CH_GT:     ds_mode = MODE_GT;
                CH_BANG:   ds_mode = MODE_BANG;
                CH_EQ:     begin ds_tok = 1'b1; ds_kind = K_EQ;    end
                CH_COMMA:  begin ds_tok = 1'b1; ds_kind = K_COMMA; end
                CH_SEMI:   begin ds_tok = 1'b1; ds_kind = K_SEMI;  end
                CH_LPAREN: begin ds_tok = 1'b1; ds_kind = K_LPAR;  end
                CH_RPAREN: begin ds_tok = 1'b1; ds_kind = K_RPAR;  end
                CH_STAR:   begin ds_tok = 1'b1; ds_kind = K_STAR;  end
                default:   begin ds_tok = 1'b1; ds_kind = K_BAD;   end
            endcase
        end
    end

    // pending token, ending at the current offset, or one past its begin for a one-character operator
    always_comb
    begin
        fl_valid = 1'b1;
        fl_kind  = K_BAD;
        fl_end   = p_ext;
        case (mode_reg)
            MODE_WORD:             fl_kind = word_kind;
            MODE_INT, MODE_FRAC:   fl_kind = K_NUM;
            MODE_STR, MODE_STRQ:   fl_kind = K_STR;
            MODE_DASH, MODE_BANG:  begin fl_kind = K_BAD; fl_end = b1; end
            MODE_LT:               begin fl_kind = K_LT;  fl_end = b1; end
            MODE_GT:               begin fl_kind = K_GT;  fl_end = b1; end
            default:               fl_valid = 1'b0;
        endcase
    end

    always_comb
    begin
        logic       redo;
        logic       do_dispatch;
        logic       word_add;
        logic [3:0] base_cnt;
        logic       base_long;

        mode_next   = mode_reg;
        begin_next  = begin_reg;
        offset_next = offset_reg;
        sat_next    = sat_reg;
        cnt_next    = cnt_reg;
        long_next   = long_reg;
        a_valid     = 1'b0;
        a_kind      = K_END;
        a_end       = p_ext;
        b_valid     = 1'b0;
        b_kind      = K_END;
        b_end       = p1;
        redo        = 1'b0;
        do_dispatch = 1'b0;
        word_add    = 1'b0;
        kw_we       = 1'b0;
        kw_idx      = cnt_reg;
        base_cnt    = cnt_reg;
        base_long   = long_reg;

        if (item.end_of_text)
        begin
            a_valid     = fl_valid;
            a_kind      = fl_kind;
            a_end       = fl_end;
            b_valid     = 1'b1;
            b_kind      = K_END;
            b_end       = p_ext;
            mode_next   = MODE_IDLE;
            begin_next  = '0;
            offset_next = '0;
            sat_next    = 1'b0;
            cnt_next    = '0;
            long_next   = 1'b0;
        end
        else
        begin
            case (mode_reg)
                MODE_WORD:
                begin
                    if (is_word) word_add = 1'b1;
                    else redo = 1'b1;
                end
                MODE_INT:
                begin
                    if (c == CH_DOT) mode_next = MODE_FRAC;
                    else if (!is_digit) redo = 1'b1;
                end
                MODE_FRAC:
                begin
                    if (!is_digit) redo = 1'b1;
                end
                MODE_STR:
                begin
                    if (c == CH_QUOTE) mode_next = MODE_STRQ;
                end
                MODE_STRQ:
                begin
                    if (c == CH_QUOTE) mode_next = MODE_STR;
                    else redo = 1'b1;
                end
                MODE_DASH:
                begin
                    if (c == CH_DASH) mode_next = MODE_COMMENT;
                    else redo = 1'b1;
                end
                MODE_COMMENT:
                begin
                    if (c == CH_LF) mode_next = MODE_IDLE;
                end
                MODE_LT:
                begin
                    if (c == CH_EQ || c == CH_GT)
                    begin
                        a_valid   = 1'b1;
                        a_kind    = (c == CH_EQ) ? K_LE : K_NE;
                        a_end     = p1;
                        mode_next = MODE_IDLE;
                    end
                    else redo = 1'b1;
                end
                MODE_GT, MODE_BANG:
                begin
                    if (c == CH_EQ)
                    begin
                        a_valid   = 1'b1;
                        a_kind    = (mode_reg == MODE_GT) ? K_GE : K_NE;
                        a_end     = p1;
                        mode_next = MODE_IDLE;
                    end
                    else redo = 1'b1;
                end
                default:
                begin
                    do_dispatch = 1'b1;
                end
            endcase

            if (redo)
            begin
                a_valid     = fl_valid;
                a_kind      = fl_kind;
                a_end       = fl_end;
                do_dispatch = 1'b1;
            end

            if (do_dispatch)
            begin
                mode_next  = ds_mode;
                begin_next = offset_reg;
                b_valid    = ds_tok;
                b_kind     = ds_kind;
                word_add   = ds_word;
            end

            // a new word restarts the keyword buffer
            base_cnt  = do_dispatch ? 4'd0 : cnt_reg;
            base_long = do_dispatch ? 1'b0 : long_reg;
            if (word_add)
            begin
                kw_idx = base_cnt;
                if (base_cnt < KW_DEPTH_C)
                begin
                    kw_we     = 1'b1;
                    cnt_next  = base_cnt + 4'd1;
                    long_next = base_long;
                end
                else
                begin
                    cnt_next  = base_cnt;
                    long_next = 1'b1;
                end
            end

            if (offset_reg == OFF_MAX) sat_next = 1'b1;
            else offset_next = offset_reg + 1'b1;
        end
    end

    // pack the two candidate tokens, flushed one first
    always_comb
    begin
        s0_kind  = a_valid ? a_kind : b_kind;
        s0_begin = a_valid ? begin_reg : offset_reg;
        s0_end   = a_valid ? a_end : b_end;
    end

    sts_tok_fmt #(.OFFSET_BITS(OFFSET_BITS)) u_fmt0 (
        .kind      (s0_kind),
        .tok_begin (s0_begin),
        .tok_end   (s0_end),
        .sat       (sat_reg),
        .item      (e0_raw)
    );

    sts_tok_fmt #(.OFFSET_BITS(OFFSET_BITS)) u_fmt1 (
        .kind      (b_kind),
        .tok_begin (offset_reg),
        .tok_end   (b_end),
        .sat       (sat_reg),
        .item      (e1_raw)
    );

    always_comb
    begin
        push.count          = accept ? (2'(a_valid) + 2'(b_valid)) : 2'd0;
        push.e0             = e0_raw;
        push.e0.last_of_run = !(a_valid && b_valid);
        push.e1             = e1_raw;
        push.e1.last_of_run = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            begin_reg  <= '0;
            offset_reg <= '0;
            sat_reg    <= 1'b0;
            cnt_reg    <= '0;
            long_reg   <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg   <= mode_next;
            begin_reg  <= begin_next;
            offset_reg <= offset_next;
            sat_reg    <= sat_next;
            cnt_reg    <= cnt_next;
            long_reg   <= long_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && kw_we)
        begin
            kw_chars_reg[kw_idx] <= c_upper;
        end
    end

endmodule

>>> rtl/core/sts_out_fifo.sv
// ----------------------------------------------------------------------------
// sts_out_fifo
// Small result queue: takes up to two items per cycle from the scanner and
// hands one per cycle to the output channel while tok_ready holds.
// ----------------------------------------------------------------------------
module sts_out_fifo
    import sts_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  sts_push_t push,
    output logic      room,
    output logic      tok_valid,
    input  logic      tok_ready,
    output sts_out_t  tok_item
);

    localparam logic [FIFO_AW:0] ROOM_LIMIT = (FIFO_AW + 1)'(FIFO_DEPTH - 2);

    sts_out_t           mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_AW:0]   fill_reg, fill_next;
    logic               pop;

    assign pop       = tok_valid && tok_ready;
    assign tok_valid = fill_reg != '0;
    assign tok_item  = mem[rd_ptr_reg];
    assign room      = fill_reg <= ROOM_LIMIT;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + FIFO_AW'(push.count);
        rd_ptr_next = rd_ptr_reg + FIFO_AW'(pop);
        fill_next   = fill_reg + (FIFO_AW + 1)'(push.count) - (FIFO_AW + 1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem[wr_ptr_reg] <= push.e0;
        end
        if (push.count == 2'd2)
        begin
            mem[wr_ptr_reg + FIFO_AW'(1)] <= push.e1;
        end
    end

endmodule

>>> tb/sv/tb_sql_token_scanner_top.sv
// ----------------------------------------------------------------------------
// tb_sql_token_scanner_top
// Self-checking bench for the streaming sql lexer. Text bytes and end
// markers go in through a valid/ready channel with random gaps. A lexer
// model in the bench tracks mode, offsets and word letters, and predicts
// the tokens of every accepted item. Tokens coming out under random
// backpressure are compared field by field, in order, with that
// prediction. Directed texts cover all non-keyword token kinds, odd bytes
// and word limits. Random sql-like statements follow.
// ----------------------------------------------------------------------------
module tb_sql_token_scanner_top
    import sts_pkg::*;
();

    localparam int OFFSET_BITS  = 16;
    localparam longint unsigned POS_MAX   = (64'd1 << OFFSET_BITS) - 64'd1;
    localparam longint unsigned FIELD_TOP = 64'd65535;
    localparam int KW_TOTAL     = 21;
    localparam int RANDOM_ITEMS = 480;
    localparam int STALL_LIMIT  = 400;
    localparam int DRAIN_CYCLES = 8;
    localparam int SHOW_LIMIT   = 10;

    logic     clk;
    logic     rst_n;
    logic     text_valid;
    logic     text_ready;
    sts_in_t  text_item;
    logic     tok_valid;
    logic     tok_ready;
    sts_out_t tok_item;

    sql_token_scanner_top #(
        .OFFSET_BITS(OFFSET_BITS)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .text_valid (text_valid),
        .text_ready (text_ready),
        .text_item  (text_item),
        .tok_valid  (tok_valid),
        .tok_ready  (tok_ready),
        .tok_item   (tok_item)
    );

    string kw_names [KW_TOTAL] = '{
        "SELECT", "INSERT", "UPDATE", "DELETE", "FROM", "WHERE", "ORDER", "BY",
        "INTO", "VALUES", "SET", "BEGIN", "COMMIT", "ROLLBACK", "JOIN",
        "INNERJOIN", "LEFTJOIN", "RIGHTJOIN", "FULLJOIN", "OUTERJOIN", "ON"
    };
    string op_texts [12] = '{
        "=", "<>", "!=", "<", "<=", ">", ">=", ",", ";", "(", ")", "*"
    };

    // lexer model state
    scan_mode_t      lex_mode;
    longint unsigned lex_begin;
    longint unsigned lex_pos;
    logic [7:0]      word_buf [KW_DEPTH];
    int              word_len;
    bit              word_long;
    bit              pos_sat;

    sts_out_t step_tokens [$];
    sts_out_t pending_tokens [$];

    int sent_count;
    int mismatches;
    bit calm;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // lexer model
    // ------------------------------------------------------------------
    task automatic lexer_clear();
        lex_mode  = MODE_IDLE;
        lex_begin = 0;
        lex_pos   = 0;
        word_len  = 0;
        word_long = 1'b0;
        pos_sat   = 1'b0;
    endtask

    function automatic bit is_letter(logic [7:0] c);
        return (c >= CH_UPPER_A && c <= CH_UPPER_Z) ||
               (c >= CH_LOWER_A && c <= CH_LOWER_Z);
    endfunction

    function automatic bit is_digit(logic [7:0] c);
        return c >= CH_DIGIT_0 && c <= CH_DIGIT_9;
    endfunction

    function automatic bit is_word_char(logic [7:0] c);
        return is_letter(c) || is_digit(c) || c == CH_UNDERSCORE;
    endfunction

    function automatic bit is_blank(logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF;
    endfunction

    task automatic add_token(input logic [5:0] kind, input longint unsigned b,
                             input longint unsigned e);
        sts_out_t        t;
        longint unsigned len;
        bit              ovf;
        len = (e >= b) ? e - b : 0;
        ovf = pos_sat;
        if (b > FIELD_TOP)
        begin
            b   = FIELD_TOP;
            ovf = 1'b1;
        end
        if (len > FIELD_TOP)
        begin
            len = FIELD_TOP;
            ovf = 1'b1;
        end
        t.token_kind      = kind;
        t.token_start     = b[15:0];
        t.token_length    = len[15:0];
        t.last_of_run     = 1'b0;
        t.offset_overflow = ovf;
        step_tokens = {step_tokens, t};
    endtask

    function automatic logic [5:0] word_kind();
        string w;
        bit    same;
        if (word_long)
            return K_IDENT;
        for (int i = 0; i < KW_TOTAL; i++)
        begin
            w = kw_names[i];
            if (w.len() == word_len)
            begin
                same = 1'b1;
                for (int j = 0; j < word_len; j++)
                    if (word_buf[j] != w.getc(j))
                        same = 1'b0;
                if (same)
                    return K_KW0 + 6'(i);
            end
        end
        return K_IDENT;
    endfunction

    task automatic add_word_char(input logic [7:0] c);
        if (c >= CH_LOWER_A && c <= CH_LOWER_Z)
            c = c - CASE_OFFSET;
        if (word_len < KW_DEPTH)
        begin
            word_buf[word_len] = c;
            word_len++;
        end
        else
            word_long = 1'b1;
    endtask

    task automatic start_token(input logic [7:0] c, input longint unsigned p);
        lex_mode  = MODE_IDLE;
        lex_begin = p;
        if (!is_blank(c))
        begin
            if (is_letter(c) || c == CH_UNDERSCORE)
            begin
                word_len  = 0;
                word_long = 1'b0;
                add_word_char(c);
                lex_mode = MODE_WORD;
            end
            else if (is_digit(c))
                lex_mode = MODE_INT;
            else
            begin
                case (c)
                    CH_QUOTE:  lex_mode = MODE_STR;
                    CH_DASH:   lex_mode = MODE_DASH;
                    CH_LT:     lex_mode = MODE_LT;
                    CH_GT:     lex_mode = MODE_GT;
                    CH_BANG:   lex_mode = MODE_BANG;
                    CH_EQ:     add_token(K_EQ, p, p + 1);
                    CH_COMMA:  add_token(K_COMMA, p, p + 1);
                    CH_SEMI:   add_token(K_SEMI, p, p + 1);
                    CH_LPAREN: add_token(K_LPAR, p, p + 1);
                    CH_RPAREN: add_token(K_RPAR, p, p + 1);
                    CH_STAR:   add_token(K_STAR, p, p + 1);
                    default:   add_token(K_BAD, p, p + 1);
                endcase
            end
        end
    endtask

    // close the token in progress, ending just before offset p, or one past its begin for a one-character operator
    task automatic flush_token(input longint unsigned p);
        case (lex_mode)
            MODE_WORD:             add_token(word_kind(), lex_begin, p);
            MODE_INT, MODE_FRAC:   add_token(K_NUM, lex_begin, p);
            MODE_STR, MODE_STRQ:   add_token(K_STR, lex_begin, p);
            MODE_DASH, MODE_BANG:  add_token(K_BAD, lex_begin, lex_begin + 1);
            MODE_LT:               add_token(K_LT, lex_begin, lex_begin + 1);
            MODE_GT:               add_token(K_GT, lex_begin, lex_begin + 1);
            default:               ;
        endcase
    endtask

    task automatic predict_tokens(input sts_in_t it);
        logic [7:0]      c;
        longint unsigned p;
        longint unsigned b;
        bit              redo;
        sts_out_t        t;
        c    = it.char_code;
        p    = lex_pos;
        b    = lex_begin;
        redo = 1'b0;
        step_tokens.delete();
        if (it.end_of_text)
        begin
            flush_token(p);
            add_token(K_END, p, p);
            lexer_clear();
        end
        else
        begin
            case (lex_mode)
                MODE_WORD:
                    if (is_word_char(c))
                        add_word_char(c);
                    else
                        redo = 1'b1;
                MODE_INT:
                    if (c == CH_DOT)
                        lex_mode = MODE_FRAC;
                    else if (!is_digit(c))
                        redo = 1'b1;
                MODE_FRAC:
                    if (!is_digit(c))
                        redo = 1'b1;
                MODE_STR:
                    if (c == CH_QUOTE)
                        lex_mode = MODE_STRQ;
                MODE_STRQ:
                    if (c == CH_QUOTE)
                        lex_mode = MODE_STR;
                    else
                        redo = 1'b1;
                MODE_DASH:
                    if (c == CH_DASH)
                        lex_mode = MODE_COMMENT;
                    else
                        redo = 1'b1;
                MODE_COMMENT:
                    if (c == CH_LF)
                        lex_mode = MODE_IDLE;
                MODE_LT:
                    if (c == CH_EQ)
                    begin
                        add_token(K_LE, b, p + 1);
                        lex_mode = MODE_IDLE;
                    end
                    else if (c == CH_GT)
                    begin
                        add_token(K_NE, b, p + 1);
                        lex_mode = MODE_IDLE;
                    end
                    else
                        redo = 1'b1;
                MODE_GT:
                    if (c == CH_EQ)
                    begin
                        add_token(K_GE, b, p + 1);
                        lex_mode = MODE_IDLE;
                    end
                    else
                        redo = 1'b1;
                MODE_BANG:
                    if (c == CH_EQ)
                    begin
                        add_token(K_NE, b, p + 1);
                        lex_mode = MODE_IDLE;
                    end
                    else
                        redo = 1'b1;
                default:
                    start_token(c, p);
            endcase
            if (redo)
            begin
                flush_token(p);
                start_token(c, p);
            end
            // offset sticks at its top value once reached
            if (lex_pos >= POS_MAX)
            begin
                lex_pos = POS_MAX;
                pos_sat = 1'b1;
            end
            else
                lex_pos++;
        end
        for (int i = 0; i < step_tokens.size(); i++)
        begin
            t = step_tokens[i];
            t.last_of_run = (i == step_tokens.size() - 1);
            pending_tokens = {pending_tokens, t};
        end
    endtask

    // ------------------------------------------------------------------
    // driving
    // ------------------------------------------------------------------
    function automatic int draw_wait();
        if (calm)
            return 0;
        if ($urandom_range(0, 2) == 0)
            return $urandom_range(0, 19);
        return 0;
    endfunction

    // returns right after the rising edge that accepted the item
    task automatic send_item(input logic [7:0] ch, input logic eot);
        sts_in_t it;
        int      gap;
        it.char_code   = ch;
        it.end_of_text = eot;
        gap = draw_wait();
        @(negedge clk);
        if (gap > 0)
        begin
            text_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        text_valid <= 1'b1;
        text_item  <= it;
        @(posedge clk);
        while (!text_ready)
            @(posedge clk);
        sent_count++;
        predict_tokens(it);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_item(s.getc(i), 1'b0);
    endtask

    task automatic send_end();
        send_item(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        text_valid <= 1'b0;
        while (pending_tokens.size() != 0)
            @(negedge clk);
    endtask

    function automatic logic [7:0] blank_byte();
        case ($urandom_range(0, 3))
            0:       return CH_TAB;
            1:       return CH_CR;
            2:       return CH_LF;
            default: return CH_SPACE;
        endcase
    endfunction

    function automatic logic [7:0] word_head();
        int r;
        r = $urandom_range(0, 52);
        if (r < 26)
            return CH_UPPER_A + 8'(r);
        if (r < 52)
            return CH_LOWER_A + 8'(r - 26);
        return CH_UNDERSCORE;
    endfunction

    function automatic logic [7:0] word_tail();
        if ($urandom_range(0, 5) == 0)
            return CH_DIGIT_0 + 8'($urandom_range(0, 9));
        return word_head();
    endfunction

    task automatic send_keyword();
        string      w;
        logic [7:0] ch;
        w = kw_names[$urandom_range(0, KW_TOTAL - 1)];
        for (int j = 0; j < w.len(); j++)
        begin
            ch = w.getc(j);
            if ($urandom_range(0, 1))
                ch = ch + CASE_OFFSET;
            send_item(ch, 1'b0);
        end
    endtask

    task automatic send_word();
        int n;
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 14) : $urandom_range(1, 8);
        send_item(word_head(), 1'b0);
        repeat (n - 1) send_item(word_tail(), 1'b0);
    endtask

    task automatic send_digits(input int n);
        repeat (n) send_item(CH_DIGIT_0 + 8'($urandom_range(0, 9)), 1'b0);
    endtask

    task automatic send_number();
        send_digits($urandom_range(1, 5));
        if ($urandom_range(0, 1))
        begin
            send_item(CH_DOT, 1'b0);
            send_digits($urandom_range(0, 3));
        end
    endtask

    task automatic send_string_body();
        logic [7:0] ch;
        send_item(CH_QUOTE, 1'b0);
        repeat ($urandom_range(0, 6))
        begin
            if ($urandom_range(0, 5) == 0)
            begin
                send_item(CH_QUOTE, 1'b0);
                send_item(CH_QUOTE, 1'b0);
            end
            else
            begin
                ch = 8'($urandom_range(32, 126));
                if (ch == CH_QUOTE)
                    ch = CH_SPACE;
                send_item(ch, 1'b0);
            end
        end
    endtask

    task automatic send_comment();
        logic [7:0] ch;
        send_text("--");
        repeat ($urandom_range(0, 8))
        begin
            ch = 8'($urandom_range(0, 255));
            if (ch == CH_LF)
                ch = CH_SPACE;
            send_item(ch, 1'b0);
        end
        send_item(CH_LF, 1'b0);
    endtask

    task automatic send_random_token();
        case ($urandom_range(0, 19))
            0, 1, 2, 3:      send_keyword();
            4, 5, 6:         send_word();
            7, 8:            send_number();
            9, 10:
            begin
                send_string_body();
                send_item(CH_QUOTE, 1'b0);
            end
            15:              send_comment();
            16:              send_item(8'($urandom_range(0, 255)), 1'b0);
            default:         send_text(op_texts[$urandom_range(0, 11)]);
        endcase
    endtask

    // a statement cut short by the end marker
    task automatic send_broken_tail();
        case ($urandom_range(0, 3))
            0:       send_string_body();
            1:       send_text(op_texts[$urandom_range(0, 5)].substr(0, 0));
            2:
            begin
                send_digits($urandom_range(1, 3));
                send_item(CH_DOT, 1'b0);
            end
            default: send_word();
        endcase
        send_end();
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_operators();
        send_text("=<=<>!=>=<1>_,;()*");
        send_item(8'hFF, 1'b1);
    endtask

    // lone dash, lone bang, comment, odd bytes, trailing dot, open string
    task automatic test_odd_bytes();
        send_text("-!--x\n");
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        send_text("1..'a''");
        send_item(8'h00, 1'b1);
    endtask

    // nine-letter keyword, ten-letter word, pending operator at the end
    task automatic test_word_limits();
        send_text("innerJoin innerjoinx<");
        send_end();
    endtask

    task automatic test_random_statements();
        int first_item;
        bit paused;
        first_item = sent_count;
        paused     = 1'b0;
        while (sent_count - first_item < RANDOM_ITEMS)
        begin
            calm = ($urandom_range(0, 4) == 0);
            repeat ($urandom_range(3, 10))
            begin
                send_random_token();
                if ($urandom_range(0, 5) != 0)
                    send_item(blank_byte(), 1'b0);
            end
            case ($urandom_range(0, 5))
                0:       send_broken_tail();
                1, 2:
                begin
                    send_text(";");
                    send_end();
                end
                default: send_text(";");
            endcase
            if (!paused || $urandom_range(0, 7) == 0)
            begin
                wait_drained();
                paused = 1'b1;
            end
        end
        calm = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------
    initial
    begin : tok_stall
        int w;
        tok_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            w = draw_wait();
            @(negedge clk);
            if (w > 0)
            begin
                tok_ready <= 1'b0;
                repeat (w) @(negedge clk);
            end
            tok_ready <= 1'b1;
            @(posedge clk);
            while (!tok_valid)
                @(posedge clk);
        end
    end

    task automatic check_token(input sts_out_t got);
        sts_out_t want;
        if (pending_tokens.size() == 0)
        begin
            mismatches++;
            if (mismatches <= SHOW_LIMIT)
                $display("unexpected token: kind %0d start %0d len %0d last %0b ovf %0b",
                         got.token_kind, got.token_start, got.token_length,
                         got.last_of_run, got.offset_overflow);
        end
        else
        begin
            want = pending_tokens.pop_front();
            if (got.token_kind !== want.token_kind ||
                got.token_start !== want.token_start ||
                got.token_length !== want.token_length ||
                got.last_of_run !== want.last_of_run ||
                got.offset_overflow !== want.offset_overflow)
            begin
                mismatches++;
                if (mismatches <= SHOW_LIMIT)
                    $display("token mismatch: exp %0d/%0d/%0d/%0b/%0b got %0d/%0d/%0d/%0b/%0b",
                             want.token_kind, want.token_start, want.token_length,
                             want.last_of_run, want.offset_overflow,
                             got.token_kind, got.token_start, got.token_length,
                             got.last_of_run, got.offset_overflow);
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && tok_valid && tok_ready)
            check_token(tok_item);
    end

    initial
    begin : watchdog
        int stalled;
        stalled = 0;
        while (stalled < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (text_valid && text_ready) || (tok_valid && tok_ready))
                stalled = 0;
            else
                stalled++;
        end
        $display("sql_token_scanner_top regression: fail");
        $finish;
    end

    initial
    begin
        rst_n      = 1'b0;
        text_valid = 1'b0;
        text_item  = '0;
        calm       = 1'b0;
        sent_count = 0;
        mismatches = 0;
        lexer_clear();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_operators();
        test_odd_bytes();
        test_word_limits();
        test_random_statements();

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatches == 0 && pending_tokens.size() == 0)
            $display("sql_token_scanner_top regression: pass");
        else
            $display("sql_token_scanner_top regression: fail");
        $finish;
    end

endmodule
